@@ hdl/ffp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffp_pkg: shared types and codes for the first-fit extent placer
// Command codes, payload types and the sequencer state type.
// ----------------------------------------------------------------------------
package ffp_pkg;

  // payload field types
  typedef logic [1:0]  cmd_t;
  typedef logic [5:0]  entry_index_t;
  typedef logic [31:0] section_size_t;
  typedef logic [31:0] slot_offset_t;
  typedef logic [15:0] header_length_t;

  // command codes; the fourth code does nothing
  localparam cmd_t CMD_PLACE  = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_CLEAR  = 2'd2;

  // header length after reset
  localparam header_length_t HEADER_RESET = 16'd64;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_STEP,
    ST_DONE
  } ffp_state_t;

endpackage : ffp_pkg
`default_nettype wire

@@ hdl/ffp_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffp_req_if: command channel of the extent placer
// Valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
interface ffp_req_if;
  logic                   valid;
  logic                   ready;
  ffp_pkg::cmd_t          cmd;
  ffp_pkg::entry_index_t  entry_index;
  ffp_pkg::section_size_t section_size;

  modport source (output valid, output cmd, output entry_index, output section_size,
                  input ready);
  modport sink   (input valid, input cmd, input entry_index, input section_size,
                  output ready);
endinterface : ffp_req_if
`default_nettype wire

@@ hdl/ffp_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffp_rsp_if: result channel of the extent placer
// Valid/ready channel carrying one placement result transaction.
// ----------------------------------------------------------------------------
interface ffp_rsp_if;
  logic                  valid;
  logic                  ready;
  ffp_pkg::slot_offset_t slot_offset;
  logic                  overflow;

  modport source (output valid, output slot_offset, output overflow, input ready);
  modport sink   (input valid, input slot_offset, input overflow, output ready);
endinterface : ffp_rsp_if
`default_nettype wire

@@ hdl/ffp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffp_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : ffp_ram
`default_nettype wire

@@ hdl/first_fit_extent_placer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_extent_placer: first-fit placement of extents in an offset space
// Keeps one extent (start, length, valid) per entry and places new extents
// at the lowest free offset at or above the header length.
// ----------------------------------------------------------------------------
// Usage:
//   request  : command transactions (place, remove, clear) with entry index
//              and section size; taken only while the block is idle.
//   response : one transaction per place command (slot offset, overflow);
//              remove, clear, unused codes and out-of-range indexes give none.
//   cfg_wr_en/cfg_wr_data : write the header length while idle.
// Sequencing:
//   remove and unused commands finish in the cycle they are accepted; clear
//   sweeps every entry of the table memory. A place command runs one scan
//   pass for every extent it visits in offset order plus one final pass; a
//   pass reads every entry of the table and then enters the step state. The
//   single read port of the table memory is read once per entry in each pass.
// Reset:
//   after rst the block sweeps the table before it is ready; header length
//   returns to 64.
// Stall:
//   the result sits in an output register; a finished placement waits for
//   that register to drain before it commits and returns to idle.
// ----------------------------------------------------------------------------
module first_fit_extent_placer #(
  parameter int ENTRIES      = 64,
  parameter int OFFSET_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_wr_en,
  input  wire ffp_pkg::header_length_t cfg_wr_data,
  ffp_req_if.sink                      request,
  ffp_rsp_if.source                    response
);

  localparam int IW = $clog2(ENTRIES);
  localparam int OW = OFFSET_WIDTH;
  localparam int SW = ((OW > 32) ? OW : 32) + 1;
  localparam int RW = 2 * OW + 1;
  localparam int KW = OW + IW;

  // sequencer and datapath registers
  ffp_pkg::ffp_state_t state, state_next;

  ffp_pkg::header_length_t header_length;
  logic [IW-1:0]  clr_cnt;
  logic [IW:0]    scan_cnt;
  logic           rd_pend;
  logic [IW-1:0]  rd_idx;
  logic [OW-1:0]  cand;
  logic [31:0]    size_q;
  logic [IW-1:0]  idx_q;
  logic           have_last;
  logic [KW-1:0]  last_key;
  logic           have_best;
  logic [OW-1:0]  best_start;
  logic [OW-1:0]  best_len;
  logic [IW-1:0]  best_idx;
  logic           out_valid;
  logic [31:0]    out_offset;
  logic           out_ovf;

  // memory port signals
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;

  // decoded read data and datapath logic
  logic          e_valid;
  logic [OW-1:0] e_len;
  logic [OW-1:0] e_start;
  logic [KW-1:0] e_key;
  logic          e_take;
  logic [SW-1:0] fit_end;
  logic          ovf;
  logic          stop_here;
  logic [OW:0]   best_end;
  logic          accept;
  logic          idx_ok;
  logic          out_free;
  logic          scan_issue;

  ffp_ram #(
    .WIDTH (RW),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entry word layout: valid, length, start
  assign e_valid = ram_rdata[RW-1];
  assign e_len   = ram_rdata[2*OW-1:OW];
  assign e_start = ram_rdata[OW-1:0];
  assign e_key   = {e_start, rd_idx};

  // next extent in (start, index) order beyond the last one visited
  assign e_take = rd_pend && e_valid && (e_len != '0)
               && (!have_last || (e_key > last_key))
               && (!have_best || (e_key < {best_start, best_idx}));

  // shared adder: candidate end of the requested extent
  assign fit_end   = SW'(cand) + SW'(size_q);
  assign ovf       = (fit_end[SW-1:OW] != '0);
  assign stop_here = (SW'(best_start) >= fit_end);
  assign best_end  = (OW+1)'(best_start) + (OW+1)'(best_len);

  assign accept     = request.valid && request.ready;
  assign idx_ok     = (32'(request.entry_index) < 32'(ENTRIES));
  assign out_free   = !out_valid || response.ready;
  assign scan_issue = (scan_cnt < (IW+1)'(ENTRIES));
  assign ram_raddr  = scan_cnt[IW-1:0];

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffp_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state, memory writes and ready
  always_comb begin
    state_next    = state;
    ram_we        = 1'b0;
    ram_waddr     = clr_cnt;
    ram_wdata     = '0;
    request.ready = 1'b0;
    unique case (state)
      ffp_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_cnt == IW'(ENTRIES - 1)) begin
          state_next = ffp_pkg::ST_IDLE;
        end
      end
      ffp_pkg::ST_IDLE: begin
        request.ready = 1'b1;
        ram_waddr     = IW'(request.entry_index);
        if (accept) begin
          priority if (request.cmd == ffp_pkg::CMD_CLEAR) begin
            state_next = ffp_pkg::ST_CLEAR;
          end else if (request.cmd == ffp_pkg::CMD_REMOVE && idx_ok) begin
            ram_we = 1'b1;
          end else if (request.cmd == ffp_pkg::CMD_PLACE && idx_ok) begin
            state_next = ffp_pkg::ST_SCAN;
          end else begin
            state_next = ffp_pkg::ST_IDLE;
          end
        end
      end
      ffp_pkg::ST_SCAN: begin
        if (!scan_issue && !rd_pend) begin
          state_next = ffp_pkg::ST_STEP;
        end
      end
      ffp_pkg::ST_STEP: begin
        if (!have_best || stop_here) begin
          state_next = ffp_pkg::ST_DONE;
        end else begin
          state_next = ffp_pkg::ST_SCAN;
        end
      end
      ffp_pkg::ST_DONE: begin
        ram_waddr = idx_q;
        ram_wdata = {1'b1, OW'(size_q), cand};
        if (out_free) begin
          ram_we     = !ovf;
          state_next = ffp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ffp_pkg::ST_CLEAR;
      end
    endcase
  end

  // header length register
  always_ff @(posedge clk) begin
    if (rst) begin
      header_length <= ffp_pkg::HEADER_RESET;
    end else if (cfg_wr_en) begin
      header_length <= cfg_wr_data;
    end
  end

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == ffp_pkg::ST_CLEAR) begin
      clr_cnt <= (clr_cnt == IW'(ENTRIES - 1)) ? '0 : clr_cnt + 1'b1;
    end
  end

  // scan pass: one read per cycle, track the smallest key beyond the last
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt  <= '0;
      rd_pend   <= 1'b0;
      have_last <= 1'b0;
      have_best <= 1'b0;
    end else begin
      rd_pend <= (state == ffp_pkg::ST_SCAN) && scan_issue;
      unique case (state)
        ffp_pkg::ST_IDLE: begin
          if (accept) begin
            scan_cnt  <= '0;
            have_last <= 1'b0;
            have_best <= 1'b0;
          end
        end
        ffp_pkg::ST_SCAN: begin
          if (scan_issue) begin
            scan_cnt <= scan_cnt + 1'b1;
          end
          if (e_take) begin
            have_best <= 1'b1;
          end
        end
        ffp_pkg::ST_STEP: begin
          if (have_best && !stop_here) begin
            have_last <= 1'b1;
            have_best <= 1'b0;
            scan_cnt  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath payload registers
  always_ff @(posedge clk) begin
    rd_idx <= scan_cnt[IW-1:0];
    if (state == ffp_pkg::ST_IDLE && accept) begin
      cand   <= OW'(header_length);
      size_q <= request.section_size;
      idx_q  <= IW'(request.entry_index);
    end
    if (state == ffp_pkg::ST_SCAN && e_take) begin
      best_start <= e_start;
      best_len   <= e_len;
      best_idx   <= rd_idx;
    end
    if (state == ffp_pkg::ST_STEP && have_best && !stop_here) begin
      last_key <= {best_start, best_idx};
      // candidate never moves backwards
      if (best_end > (OW+1)'(cand)) begin
        cand <= best_end[OW-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ffp_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ffp_pkg::ST_DONE && out_free) begin
      out_offset <= 32'(cand);
      out_ovf    <= ovf;
    end
  end

  assign response.valid       = out_valid;
  assign response.slot_offset = out_offset;
  assign response.overflow    = out_ovf;

endmodule : first_fit_extent_placer
`default_nettype wire

@@ sim/first_fit_extent_placer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_extent_placer_tb: self-checking testbench of the extent placer
// Drives place, remove, clear and unused commands, directed first and random
// after, under several header lengths. A local first-fit model predicts
// each placement result that no directed row types in by hand. Both channels
// idle at random. One long receiver hold-off lets the block back up onto its command channel.
// ----------------------------------------------------------------------------
module first_fit_extent_placer_tb;

  localparam int    ENTRIES      = 64;
  localparam int    DRAIN_CYCLES = ENTRIES + 36;
  localparam int    HOLD_CYCLES  = 2000;
  localparam int    PHASE_ITEMS  = 100;
  localparam int    PHASES       = 5;
  localparam int    DIR_COUNT    = 17;
  localparam ffp_pkg::cmd_t CMD_NOP = 2'd3;
  localparam logic [32:0] OFS_LIMIT = 33'h0_FFFF_FFFF;

  // one placement result transaction
  typedef struct packed {
    ffp_pkg::slot_offset_t slot_offset;
    logic                  overflow;
  } placement_t;

  // one directed row; lit marks an expectation typed in by hand
  typedef struct packed {
    ffp_pkg::cmd_t          cmd;
    ffp_pkg::entry_index_t  idx;
    ffp_pkg::section_size_t size;
    logic                   lit;
    ffp_pkg::slot_offset_t  off;
    logic                   ovf;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{ffp_pkg::CMD_PLACE,  6'd0,  32'd16,        1'b1, 32'd64,        1'b0}, // empty table
    '{ffp_pkg::CMD_PLACE,  6'd1,  32'd0,         1'b1, 32'd64,        1'b0}, // size zero
    '{ffp_pkg::CMD_PLACE,  6'd2,  32'd32,        1'b0, 32'd0,         1'b0},
    '{ffp_pkg::CMD_PLACE,  6'd63, 32'hFFFF_FFFF, 1'b0, 32'd0,         1'b0}, // overflow
    '{ffp_pkg::CMD_REMOVE, 6'd0,  32'd0,         1'b0, 32'd0,         1'b0},
    '{ffp_pkg::CMD_PLACE,  6'd3,  32'd16,        1'b0, 32'd0,         1'b0}, // fits hole
    '{ffp_pkg::CMD_REMOVE, 6'd63, 32'hFFFF_FFFF, 1'b0, 32'd0,         1'b0}, // never valid
    '{ffp_pkg::CMD_PLACE,  6'd2,  32'd8,         1'b0, 32'd0,         1'b0}, // own extent
    '{ffp_pkg::CMD_PLACE,  6'd3,  32'd0,         1'b0, 32'd0,         1'b0}, // shrink
    '{CMD_NOP,             6'd42, 32'h5A5A_A5A5, 1'b0, 32'd0,         1'b0},
    '{ffp_pkg::CMD_CLEAR,  6'd21, 32'd0,         1'b0, 32'd0,         1'b0},
    '{ffp_pkg::CMD_PLACE,  6'd5,  32'hFFFF_FFBF, 1'b1, 32'd64,        1'b0}, // fills range
    '{ffp_pkg::CMD_PLACE,  6'd6,  32'd1,         1'b1, 32'hFFFF_FFFF, 1'b1}, // past top
    '{ffp_pkg::CMD_PLACE,  6'd7,  32'd0,         1'b0, 32'd0,         1'b0},
    '{ffp_pkg::CMD_CLEAR,  6'd63, 32'hFFFF_FFFF, 1'b0, 32'd0,         1'b0},
    '{ffp_pkg::CMD_PLACE,  6'd10, 32'h100,       1'b1, 32'd64,        1'b0}, // after clear
    '{ffp_pkg::CMD_REMOVE, 6'd10, 32'd0,         1'b0, 32'd0,         1'b0}
  };

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en;
  ffp_pkg::header_length_t cfg_wr_data;

  ffp_req_if request_ch ();
  ffp_rsp_if response_ch ();

  // shadow extent table and header length
  logic [31:0]             ext_start [ENTRIES];
  logic [31:0]             ext_len   [ENTRIES];
  bit                      ext_live  [ENTRIES];
  ffp_pkg::header_length_t hdr_len;

  placement_t expected_placements [$];
  int         mismatch_count = 0;
  int         sent_count     = 0;
  bit         snd_burst      = 1'b0;
  bit         rcv_burst      = 1'b0;
  bit         hold_rsp       = 1'b0;

  first_fit_extent_placer #(
    .ENTRIES      (ENTRIES),
    .OFFSET_WIDTH (32)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .request     (request_ch),
    .response    (response_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lowest fitting offset: walk live extents in start order, ties by index
  function automatic logic [32:0] first_fit_offset(input ffp_pkg::section_size_t sz);
    bit          seen [ENTRIES];
    logic [32:0] cand;
    logic [32:0] ext_end;
    int          n;
    int          i;
    int          best;
    cand = {17'd0, hdr_len};
    for (i = 0; i < ENTRIES; i++) seen[i] = 1'b0;
    for (n = 0; n < ENTRIES; n++) begin
      best = -1;
      for (i = 0; i < ENTRIES; i++) begin
        if (ext_live[i] && !seen[i] && ext_len[i] != 32'd0) begin
          if (best < 0 || ext_start[i] < ext_start[best]) best = i;
        end
      end
      if (best < 0) break;
      seen[best] = 1'b1;
      if ({1'b0, ext_start[best]} >= cand + {1'b0, sz}) break;
      ext_end = {1'b0, ext_start[best]} + {1'b0, ext_len[best]};
      if (ext_end > cand) cand = ext_end;
    end
    return cand;
  endfunction

  // update the shadow table for one command and report its result, if any
  task automatic apply_command(input ffp_pkg::cmd_t c, input ffp_pkg::entry_index_t idx,
                               input ffp_pkg::section_size_t sz, output bit has_rsp,
                               output placement_t rsp);
    logic [32:0] cand;
    logic        ovf;
    int          i;
    has_rsp = 1'b0;
    rsp     = '0;
    case (c)
      ffp_pkg::CMD_CLEAR: begin
        for (i = 0; i < ENTRIES; i++) ext_live[i] = 1'b0;
      end
      ffp_pkg::CMD_REMOVE: begin
        ext_live[idx] = 1'b0;
      end
      ffp_pkg::CMD_PLACE: begin
        cand = first_fit_offset(sz);
        ovf  = (cand + {1'b0, sz}) > OFS_LIMIT;
        if (!ovf) begin
          ext_start[idx] = cand[31:0];
          ext_len[idx]   = sz;
          ext_live[idx]  = 1'b1;
        end
        has_rsp         = 1'b1;
        rsp.slot_offset = cand[31:0];
        rsp.overflow    = ovf;
      end
      default: ;
    endcase
  endtask

  // offer one command transaction after a random gap, then record its result
  task automatic send_item(input ffp_pkg::cmd_t c, input ffp_pkg::entry_index_t idx,
                           input ffp_pkg::section_size_t sz, input bit lit,
                           input placement_t lit_rsp);
    int         gap;
    bit         has_rsp;
    placement_t pred;
    placement_t want_rsp;
    if (sent_count % 20 == 0) snd_burst = ($urandom_range(0, 3) == 0);
    gap = snd_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      request_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_ch.valid        <= 1'b1;
    request_ch.cmd          <= c;
    request_ch.entry_index  <= idx;
    request_ch.section_size <= sz;
    do @(posedge clk); while (!request_ch.ready);
    apply_command(c, idx, sz, has_rsp, pred);
    if (has_rsp) begin
      want_rsp            = lit ? lit_rsp : pred;
      expected_placements = {expected_placements, want_rsp};
    end
    sent_count++;
  endtask

  // let every result and any trailing clear sweep finish
  task automatic wait_drained();
    request_ch.valid <= 1'b0;
    while (expected_placements.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_header(input ffp_pkg::header_length_t value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    hdr_len = value;
  endtask

  // random command: mostly small placements so the table fills up
  task automatic random_item(output ffp_pkg::cmd_t c, output ffp_pkg::entry_index_t idx,
                             output ffp_pkg::section_size_t sz);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)      c = ffp_pkg::CMD_PLACE;
    else if (r < 94) c = ffp_pkg::CMD_REMOVE;
    else if (r < 97) c = ffp_pkg::CMD_CLEAR;
    else             c = CMD_NOP;
    if ($urandom_range(0, 3) != 0) idx = ffp_pkg::entry_index_t'($urandom_range(0, 15));
    else idx = ffp_pkg::entry_index_t'($urandom_range(0, ENTRIES - 1));
    r = $urandom_range(0, 99);
    if (r < 5)       sz = 32'd0;
    else if (r < 75) sz = $urandom_range(1, 4096);
    else if (r < 85) sz = $urandom_range(1, 32'h00FF_FFFF);
    else if (r < 95) sz = $urandom();
    else             sz = 32'hFFFF_FFFF - $urandom_range(0, 70000);
  endtask

  // stimulus: reset, directed table, then random phases per header length
  initial begin : stimulus
    int                      k;
    int                      p;
    ffp_pkg::cmd_t           c;
    ffp_pkg::entry_index_t   idx;
    ffp_pkg::section_size_t  sz;
    placement_t              lit_rsp;
    ffp_pkg::header_length_t hdr_val;
    request_ch.valid        <= 1'b0;
    request_ch.cmd          <= ffp_pkg::CMD_PLACE;
    request_ch.entry_index  <= '0;
    request_ch.section_size <= '0;
    cfg_wr_en               <= 1'b0;
    cfg_wr_data             <= '0;
    rst                     <= 1'b1;
    hdr_len = ffp_pkg::HEADER_RESET;
    for (k = 0; k < ENTRIES; k++) begin
      ext_live[k]  = 1'b0;
      ext_start[k] = '0;
      ext_len[k]   = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    for (k = 0; k < DIR_COUNT; k++) begin
      lit_rsp.slot_offset = DIR_ROWS[k].off;
      lit_rsp.overflow    = DIR_ROWS[k].ovf;
      send_item(DIR_ROWS[k].cmd, DIR_ROWS[k].idx, DIR_ROWS[k].size,
                DIR_ROWS[k].lit, lit_rsp);
    end

    // random phases, header length changed only while idle
    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0:       hdr_val = 16'd0;
        1:       hdr_val = 16'hFFFF;
        3:       hdr_val = ffp_pkg::HEADER_RESET;
        default: hdr_val = 16'($urandom_range(0, 16'hFFFF));
      endcase
      write_header(hdr_val);
      if (p == 2) hold_rsp = 1'b1;
      k = 0;
      while (k < PHASE_ITEMS) begin
        random_item(c, idx, sz);
        send_item(c, idx, sz, 1'b0, '0);
        if (c != CMD_NOP) k++;
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result receiver: random stalls, one long hold-off on request
  initial begin : response_sink
    int stall;
    int got;
    got = 0;
    response_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (got % 16 == 0) rcv_burst = ($urandom_range(0, 3) == 0);
      stall = rcv_burst ? 0 : $urandom_range(0, 8);
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        stall    = HOLD_CYCLES;
      end
      if (stall > 0) begin
        response_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      response_ch.ready <= 1'b1;
      do @(posedge clk); while (!(response_ch.valid && response_ch.ready));
      got++;
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    placement_t want;
    if (!rst && response_ch.valid && response_ch.ready) begin
      if (expected_placements.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual offset=%h overflow=%b",
                 $time, response_ch.slot_offset, response_ch.overflow);
        mismatch_count++;
      end else begin
        want = expected_placements.pop_front();
        if (response_ch.slot_offset !== want.slot_offset) begin
          $display("%0t: slot_offset mismatch: expected %h actual %h",
                   $time, want.slot_offset, response_ch.slot_offset);
          mismatch_count++;
        end
        if (response_ch.overflow !== want.overflow) begin
          $display("%0t: overflow mismatch: expected %b actual %b",
                   $time, want.overflow, response_ch.overflow);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  initial begin : watchdog
    #200_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule : first_fit_extent_placer_tb

@@ files.f @@
hdl/ffp_pkg.sv
hdl/ffp_req_if.sv
hdl/ffp_rsp_if.sv
hdl/ffp_ram.sv
hdl/first_fit_extent_placer.sv
sim/first_fit_extent_placer_tb.sv
